// ===== rtl/fde_pkg.sv =====
// Shared constants and types of the feedback delay echo block.
`default_nettype none

package fde_pkg;

    // Default sizes of the delay memory and the audio samples.
    localparam int DEF_MAX_DELAY    = 131072;
    localparam int DEF_SAMPLE_WIDTH = 16;

    // Register and result field widths.
    localparam int LEN_W       = 17;
    localparam int GAIN_W      = 15;
    localparam int WET_W       = 16;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 3;
    localparam int PEAK_W      = 16;
    localparam int MSL_W       = 31;
    localparam int MS_W        = 32;

    // Filter states carry this many fraction bits below the sample scale.
    localparam int STATE_FRAC = 8;

    // Q15 coefficients and limits.
    localparam int LP_ALPHA = 3277;
    localparam int HP_ALPHA = 1638;
    localparam int MS_KEEP  = 32735;
    localparam int MS_TAKE  = 33;
    localparam int MS_ROUND = 16384;
    localparam int UNITY    = 32768;
    localparam int GAIN_MAX = 32440;

    // Register values after reset.
    localparam int RST_DELAY_LENGTH  = 12000;
    localparam int RST_FEEDBACK_GAIN = 9830;
    localparam int RST_WET_MIX       = 16384;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DELAY_LENGTH    = 3'd0,
        REG_FEEDBACK_GAIN   = 3'd1,
        REG_WET_MIX         = 3'd2,
        REG_BYPASS          = 3'd3,
        REG_ANALYSIS_ENABLE = 3'd4
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/fde_if.sv =====
// Stream interfaces for the sample input and the result output of the echo block.
`default_nettype none

interface fde_in_if
    import fde_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           end_of_block;

    modport source (output valid, output sample_in, output end_of_block, input ready);
    modport sink (input valid, input sample_in, input end_of_block, output ready);
endinterface

interface fde_out_if
    import fde_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           block_end_out;
    logic [PEAK_W-1:0]              peak_out;
    logic [MSL_W-1:0]               mean_square_level;

    modport source (
        output valid, output sample_out, output block_end_out,
        output peak_out, output mean_square_level, input ready
    );
    modport sink (
        input valid, input sample_out, input block_end_out,
        input peak_out, input mean_square_level, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/feedback_delay_echo_core.sv =====
// Feedback delay echo: delay memory, lowpass/highpass feedback path, wet/dry mix, analysis.
//
//   channel       role    transfer                      payload
//   sample_chan   sink    valid & ready at clk edge     sample_in, end_of_block
//   result_chan   source  valid & ready at clk edge     sample_out, block_end_out,
//                                                       peak_out, mean_square_level
//   cfg_*         write   cfg_we high at clk edge       cfg_index, cfg_data
//
// An accepted sample passes S_QUO, S_READ, S_LP, S_HIGH, S_MUL, S_WB, S_AN and S_MS before
// the next can be accepted: one memory read, then a chain of registered multiply steps
// through both filters, the mix and the mean square update. The last step waits while the
// output register holds an untaken transaction; no new sample is accepted meanwhile.
// The delay memory is not cleared after reset. Slots not yet written since reset
// read as zero, tracked by the write pointer and a wrap flag.
`default_nettype none

module feedback_delay_echo_core
    import fde_pkg::*;
#(
    parameter int MAX_DELAY    = DEF_MAX_DELAY,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
)
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   cfg_we,
    input wire logic [CFG_INDEX_W-1:0] cfg_index,
    input wire logic [CFG_DATA_W-1:0]  cfg_data,
    fde_in_if.sink                     sample_chan,
    fde_out_if.source                  result_chan
);

    localparam int SW       = SAMPLE_WIDTH;
    localparam int SB       = SAMPLE_WIDTH + STATE_FRAC;
    localparam int WW       = SB + 18;
    localparam int AW       = $clog2(MAX_DELAY);
    localparam bit NEED_MOD = (MAX_DELAY <= (1 << LEN_W) - 1);
    localparam int QW       = (AW < LEN_W + 1) ? LEN_W + 1 - AW : 1;
    localparam int SQ_SHL   = (2 * SW <= 32) ? 32 - 2 * SW : 0;
    localparam int SQ_SHR   = (2 * SW > 32) ? 2 * SW - 32 : 0;

    localparam logic signed [13:0] LP_COEF = 14'(LP_ALPHA);
    localparam logic signed [12:0] HP_COEF = 13'(HP_ALPHA);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_QUO  = 9'b000000010,
        S_READ = 9'b000000100,
        S_LP   = 9'b000001000,
        S_HIGH = 9'b000010000,
        S_MUL  = 9'b000100000,
        S_WB   = 9'b001000000,
        S_AN   = 9'b010000000,
        S_MS   = 9'b100000000
    } state_t;

    function automatic logic signed [WW-1:0] round_shr(input logic signed [WW-1:0] v,
                                                        input int n);
        logic signed [WW-1:0] bias;
        bias = WW'(1) <<< (n - 1);
        return (v + bias) >>> n;
    endfunction

    function automatic logic signed [SB-1:0] sat_state(input logic signed [WW-1:0] v);
        logic [WW-SB:0] top;
        top = v[WW-1:SB-1];
        if ((&top) || !(|top))
            return v[SB-1:0];
        return {v[WW-1], {(SB-1){~v[WW-1]}}};
    endfunction

    function automatic logic signed [SW-1:0] sat_sample(input logic signed [WW-1:0] v);
        logic [WW-SW:0] top;
        top = v[WW-1:SW-1];
        if ((&top) || !(|top))
            return v[SW-1:0];
        return {v[WW-1], {(SW-1){~v[WW-1]}}};
    endfunction

    // Configuration registers
    logic [LEN_W-1:0]  delay_length_reg;
    logic [GAIN_W-1:0] feedback_gain_reg;
    logic [WET_W-1:0]  wet_mix_reg;
    logic              bypass_reg;
    logic              analysis_enable_reg;

    // Block state
    state_t               state_reg, state_next;
    logic [AW-1:0]        wp_reg;
    logic                 wrapped_reg;
    logic signed [SB-1:0] lp_reg;
    logic signed [SB-1:0] hp_reg;
    logic [SW-1:0]        peak_reg;
    logic [MS_W-1:0]      ms_reg;

    // Delay memory
    logic [SW-1:0] mem [MAX_DELAY];
    logic [SW-1:0] mem_q_reg;
    logic          rd_hit_reg;

    // Per-sample datapath registers
    logic signed [SW-1:0]   x_reg;
    logic                   eob_reg;
    logic signed [SB+13:0]  p_lp_reg;
    logic signed [SB-1:0]   h_reg;
    logic signed [SB+12:0]  p_hp_reg;
    logic signed [SB+15:0]  p_fb_reg;
    logic signed [SW+16:0]  p_wet_reg;
    logic signed [SW+16:0]  p_dry_reg;
    logic signed [SW-1:0]   y_reg;
    logic [MSL_W-1:0]       sq_reg;

    // Output register
    logic                 out_valid_reg;
    logic signed [SW-1:0] out_sample_reg;
    logic                 out_eob_reg;
    logic [PEAK_W-1:0]    out_peak_reg;
    logic [MSL_W-1:0]     out_ms_reg;

    // Combinational helpers
    logic [AW-1:0]        rem;
    logic [AW:0]          addr_diff;
    logic [AW-1:0]        rd_addr;
    logic                 rd_hit;
    logic [GAIN_W-1:0]    gain_eff;
    logic [WET_W-1:0]     wet_eff;
    logic signed [16:0]   wet_s;
    logic signed [16:0]   dry_s;
    logic signed [15:0]   gain_s;
    logic signed [SW-1:0] d_val;
    logic signed [SB:0]   lp_err;
    logic signed [SB-1:0] lp_new;
    logic signed [SW-1:0] wet_val;
    logic signed [SW-1:0] fb_val;
    logic [SW-1:0]        mag;
    logic [2*SW-1:0]      sq_full;
    logic [47:0]          ms_calc;
    logic [MS_W-1:0]      ms_next;
    logic                 fire_out;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_length_reg    <= LEN_W'(RST_DELAY_LENGTH);
            feedback_gain_reg   <= GAIN_W'(RST_FEEDBACK_GAIN);
            wet_mix_reg         <= WET_W'(RST_WET_MIX);
            bypass_reg          <= 1'b0;
            analysis_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DELAY_LENGTH:    delay_length_reg    <= cfg_data[LEN_W-1:0];
                REG_FEEDBACK_GAIN:   feedback_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_WET_MIX:         wet_mix_reg         <= cfg_data[WET_W-1:0];
                REG_BYPASS:          bypass_reg          <= cfg_data[0];
                REG_ANALYSIS_ENABLE: analysis_enable_reg <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Delay length reduced modulo the memory depth
    // ------------------------------------------------------------------
    generate
        if (NEED_MOD)
        begin : g_mod
            // Rounded-up reciprocal gives the exact quotient for every 17-bit length.
            localparam int K  = LEN_W + AW;
            localparam int RW = LEN_W + 1;
            localparam logic [RW-1:0] RECIP =
                RW'(((64'd1 << K) + 64'(MAX_DELAY) - 64'd1) / 64'(MAX_DELAY));

            logic [LEN_W+RW-1:0] recip_prod;
            logic [QW-1:0]       quo_reg;

            assign recip_prod = delay_length_reg * RECIP;

            always_ff @(posedge clk)
            begin
                quo_reg <= recip_prod[K +: QW];
            end

            assign rem = AW'(delay_length_reg - LEN_W'(quo_reg * MAX_DELAY));
        end
        else
        begin : g_nomod
            assign rem = AW'(delay_length_reg);
        end
    endgenerate

    always_comb
    begin
        addr_diff = {1'b0, wp_reg} - {1'b0, rem};
        rd_addr   = addr_diff[AW] ? AW'(addr_diff + (AW+1)'(MAX_DELAY)) : addr_diff[AW-1:0];
        // A slot counts as written once the pointer has passed it or wrapped.
        rd_hit    = wrapped_reg || (!addr_diff[AW] && (rem != '0));
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign fire_out = (state_reg == S_MS) && (!out_valid_reg || result_chan.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (sample_chan.valid) state_next = S_QUO;
            S_QUO:  state_next = S_READ;
            S_READ: state_next = S_LP;
            S_LP:   state_next = S_HIGH;
            S_HIGH: state_next = S_MUL;
            S_MUL:  state_next = S_WB;
            S_WB:   state_next = S_AN;
            S_AN:   state_next = S_MS;
            S_MS:   if (fire_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign sample_chan.ready = (state_reg == S_IDLE);

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    assign gain_eff = (feedback_gain_reg > GAIN_W'(GAIN_MAX)) ? GAIN_W'(GAIN_MAX)
                                                              : feedback_gain_reg;
    assign wet_eff  = (wet_mix_reg > WET_W'(UNITY)) ? WET_W'(UNITY) : wet_mix_reg;
    assign gain_s   = {1'b0, gain_eff};
    assign wet_s    = {1'b0, wet_eff};
    assign dry_s    = 17'(UNITY) - wet_s;

    assign d_val   = rd_hit_reg ? mem_q_reg : '0;
    assign lp_err  = (SB+1)'(signed'({d_val, {STATE_FRAC{1'b0}}})) - (SB+1)'(lp_reg);
    assign lp_new  = sat_state(WW'(lp_reg) + round_shr(WW'(p_lp_reg), 15));
    assign wet_val = bypass_reg ? x_reg : sat_sample(round_shr(WW'(h_reg), STATE_FRAC));
    assign fb_val  = sat_sample(WW'(x_reg) + round_shr(WW'(p_fb_reg), 23));

    assign mag     = y_reg[SW-1] ? SW'(-y_reg) : SW'(y_reg);
    assign sq_full = mag * mag;
    assign ms_calc = 48'(ms_reg) * 48'(MS_KEEP) + 48'(sq_reg) * 48'(MS_TAKE) + 48'(MS_ROUND);
    assign ms_next = ms_calc[MS_W+14:15];

    always_ff @(posedge clk)
    begin
        if (sample_chan.valid && sample_chan.ready)
        begin
            x_reg   <= sample_chan.sample_in;
            eob_reg <= sample_chan.end_of_block;
        end
        if (state_reg == S_READ)
        begin
            mem_q_reg  <= mem[rd_addr];
            rd_hit_reg <= rd_hit;
        end
        if ((state_reg == S_WB) && !bypass_reg)
            mem[wp_reg] <= fb_val;
        if (state_reg == S_LP)
            p_lp_reg <= lp_err * LP_COEF;
        if (state_reg == S_HIGH)
            h_reg <= sat_state(WW'(lp_new) - WW'(hp_reg));
        if (state_reg == S_MUL)
        begin
            p_hp_reg  <= h_reg * HP_COEF;
            p_fb_reg  <= h_reg * gain_s;
            p_wet_reg <= wet_val * wet_s;
            p_dry_reg <= x_reg * dry_s;
        end
        if (state_reg == S_WB)
            y_reg <= sat_sample(round_shr(WW'(p_dry_reg) + WW'(p_wet_reg), 15));
        if (state_reg == S_AN)
            sq_reg <= MSL_W'((64'(sq_full) << SQ_SHL) >> SQ_SHR);
        if (fire_out)
        begin
            out_sample_reg <= y_reg;
            out_eob_reg    <= eob_reg;
            out_peak_reg   <= PEAK_W'(peak_reg);
            out_ms_reg     <= analysis_enable_reg ? ms_next[MSL_W-1:0] : ms_reg[MSL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            lp_reg        <= '0;
            hp_reg        <= '0;
            peak_reg      <= '0;
            ms_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_HIGH) && !bypass_reg)
                lp_reg <= lp_new;
            if ((state_reg == S_WB) && !bypass_reg)
            begin
                hp_reg <= sat_state(WW'(hp_reg) + round_shr(WW'(p_hp_reg), 15));
                if (wp_reg == AW'(MAX_DELAY - 1))
                begin
                    wp_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    wp_reg <= wp_reg + 1'b1;
                end
            end
            if ((state_reg == S_AN) && analysis_enable_reg && (mag > peak_reg))
                peak_reg <= mag;
            if (fire_out && analysis_enable_reg)
                ms_reg <= ms_next;
            if (fire_out)
                out_valid_reg <= 1'b1;
            else if (result_chan.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign result_chan.valid             = out_valid_reg;
    assign result_chan.sample_out        = out_sample_reg;
    assign result_chan.block_end_out     = out_eob_reg;
    assign result_chan.peak_out          = out_peak_reg;
    assign result_chan.mean_square_level = out_ms_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The pointer steps by exactly one slot per processed sample, and never in bypass.
    a_wp_step : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB) && !bypass_reg |=>
            (($past(wp_reg) == AW'(MAX_DELAY - 1)) ? (wp_reg == '0)
                                                   : (wp_reg == $past(wp_reg) + 1'b1)))
        else $error("write pointer did not advance by one slot");

    a_wp_frozen : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_WB) || bypass_reg |=> $stable(wp_reg))
        else $error("write pointer moved outside a writeback");

    // Finishing a sample always leaves a transaction in the output register.
    a_result_loaded : assert property (@(posedge clk) disable iff (!rst_n)
        fire_out |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("finished sample not presented at the output");

    // The held peak never falls.
    a_peak_monotonic : assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> peak_reg >= $past(peak_reg))
        else $error("peak hold decreased");

endmodule

`default_nettype wire
